// ===== hdl/nnvr_pkg.sv =====
// Shared types, constants and helpers for the nearest-neighbor volume resize block.
// No dependencies; imported by every module of the block.
package nnvr_pkg;

  localparam int DIM_BITS     = 12;
  localparam int FRAC_BITS    = 16;
  localparam int REG_BITS     = DIM_BITS + 1;
  localparam int ACC_BITS     = DIM_BITS + 1 + FRAC_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int DIV_CNT_BITS = $clog2(ACC_BITS);

  typedef logic [DIM_BITS-1:0]     dim_t;
  typedef logic [REG_BITS-1:0]     sz_t;
  typedef logic [ACC_BITS-1:0]     acc_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [DIV_CNT_BITS-1:0] div_cnt_t;

  localparam sz_t      MAX_SIZE     = {1'b1, {DIM_BITS{1'b0}}};
  localparam sz_t      MIN_SIZE     = sz_t'(1);
  localparam acc_t     ONE_STEP     = {{(DIM_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam div_cnt_t DIV_LAST_BIT = div_cnt_t'(ACC_BITS - 1);

  // Configuration register map
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SRC_W = 3'd0,
    REG_SRC_H = 3'd1,
    REG_SRC_D = 3'd2,
    REG_DST_W = 3'd3,
    REG_DST_H = 3'd4,
    REG_DST_D = 3'd5
  } cfg_reg_t;

  // Axis being worked on by the step divider
  typedef enum logic [1:0] {
    AXIS_COL,
    AXIS_ROW,
    AXIS_SLICE
  } axis_t;

  typedef struct packed {
    sz_t col;
    sz_t row;
    sz_t slice;
  } sizes_t;

  typedef struct packed {
    dim_t col;
    dim_t row;
    dim_t slice;
  } tops_t;

  typedef struct packed {
    acc_t col;
    acc_t row;
    acc_t slice;
  } steps_t;

  typedef struct packed {
    dim_t src_col;
    dim_t src_row;
    dim_t src_plane;
    dim_t dst_col;
    dim_t dst_row;
    dim_t dst_slice;
    logic row_end;
    logic slice_end;
    logic volume_end;
  } result_t;

  // Zero acts as one, anything past the maximum clamps to it
  function automatic sz_t eff_size(sz_t v);
    sz_t r;
    if (v == '0) begin
      r = MIN_SIZE;
    end else if (v > MAX_SIZE) begin
      r = MAX_SIZE;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Largest valid index along an axis: effective size minus one
  function automatic dim_t top_index(sz_t v);
    sz_t t;
    t = eff_size(v) - MIN_SIZE;
    return t[DIM_BITS-1:0];
  endfunction

endpackage

// ===== hdl/nnvr_div.sv =====
// Step divider: restoring radix-2 division, one quotient bit per cycle, shared by 3 axes.
// Depends on nnvr_pkg.
module nnvr_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  nnvr_pkg::sizes_t src,
  input  nnvr_pkg::sizes_t dst,
  output logic            busy,
  output nnvr_pkg::steps_t steps
);
  import nnvr_pkg::*;

  axis_t    axis;
  logic     load;
  div_cnt_t cnt;
  sz_t      rem;
  acc_t     quo;

  sz_t                 sel_src;
  sz_t                 sel_dst;
  logic [REG_BITS:0]   rem_sh;
  logic [REG_BITS:0]   diff;
  logic                ge;
  sz_t                 rem_next;
  acc_t                quo_next;

  // Operand select for the axis in progress
  always_comb begin
    case (axis)
      AXIS_COL: begin
        sel_src = src.col;
        sel_dst = dst.col;
      end
      AXIS_ROW: begin
        sel_src = src.row;
        sel_dst = dst.row;
      end
      AXIS_SLICE: begin
        sel_src = src.slice;
        sel_dst = dst.slice;
      end
      default: begin
        sel_src = src.col;
        sel_dst = dst.col;
      end
    endcase
  end

  // One restoring step
  always_comb begin
    rem_sh   = {rem, quo[ACC_BITS-1]};
    diff     = rem_sh - {1'b0, sel_dst};
    ge       = rem_sh >= {1'b0, sel_dst};
    rem_next = ge ? diff[REG_BITS-1:0] : rem_sh[REG_BITS-1:0];
    quo_next = {quo[ACC_BITS-2:0], ge};
  end

  // Sequencer: load dividend, iterate, store quotient, move to next axis
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      load  <= 1'b0;
      axis  <= AXIS_COL;
      cnt   <= '0;
      steps <= '{col: ONE_STEP, row: ONE_STEP, slice: ONE_STEP};
    end else if (start) begin
      busy <= 1'b1;
      load <= 1'b1;
      axis <= AXIS_COL;
      cnt  <= '0;
    end else if (busy) begin
      if (load) begin
        load <= 1'b0;
        cnt  <= '0;
      end else if (cnt == DIV_LAST_BIT) begin
        case (axis)
          AXIS_COL: begin
            steps.col <= quo_next;
            axis      <= AXIS_ROW;
            load      <= 1'b1;
          end
          AXIS_ROW: begin
            steps.row <= quo_next;
            axis      <= AXIS_SLICE;
            load      <= 1'b1;
          end
          default: begin
            steps.slice <= quo_next;
            busy        <= 1'b0;
          end
        endcase
      end else begin
        cnt <= cnt + div_cnt_t'(1);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      quo <= {eff_size(sel_src), {FRAC_BITS{1'b0}}};
    end else begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

endmodule

// ===== hdl/nnvr_coord.sv =====
// Coordinate generator: destination counters, fixed-point source accumulators, end flags.
// Depends on nnvr_pkg.
module nnvr_coord (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic             restart,
  input  nnvr_pkg::steps_t  steps,
  input  nnvr_pkg::tops_t   src_top,
  input  nnvr_pkg::tops_t   dst_top,
  output nnvr_pkg::result_t res
);
  import nnvr_pkg::*;

  dim_t col_count, row_count, slice_count;
  acc_t col_accum, row_accum, slice_accum;

  dim_t c_col, c_row, c_slice;
  acc_t a_col, a_row, a_slice;
  sz_t  i_col, i_row, i_slice;
  logic re, se, ve;

  // Restart moves everything to the origin before this beat is served
  always_comb begin
    c_col   = restart ? '0 : col_count;
    c_row   = restart ? '0 : row_count;
    c_slice = restart ? '0 : slice_count;
    a_col   = restart ? '0 : col_accum;
    a_row   = restart ? '0 : row_accum;
    a_slice = restart ? '0 : slice_accum;
  end

  // End flags and saturated source indices
  always_comb begin
    re = c_col >= dst_top.col;
    se = re && (c_row >= dst_top.row);
    ve = se && (c_slice >= dst_top.slice);

    i_col   = a_col[ACC_BITS-1:FRAC_BITS];
    i_row   = a_row[ACC_BITS-1:FRAC_BITS];
    i_slice = a_slice[ACC_BITS-1:FRAC_BITS];

    res.src_col    = (i_col > {1'b0, src_top.col}) ? src_top.col : i_col[DIM_BITS-1:0];
    res.src_row    = (i_row > {1'b0, src_top.row}) ? src_top.row : i_row[DIM_BITS-1:0];
    res.src_plane  = (i_slice > {1'b0, src_top.slice}) ? src_top.slice
                                                        : i_slice[DIM_BITS-1:0];
    res.dst_col    = c_col;
    res.dst_row    = c_row;
    res.dst_slice  = c_slice;
    res.row_end    = re;
    res.slice_end  = se;
    res.volume_end = ve;
  end

  // Raster advance, x fastest; wraps to origin after the volume end
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      slice_count <= '0;
      col_accum   <= '0;
      row_accum   <= '0;
      slice_accum <= '0;
    end else if (take) begin
      row_count   <= c_row;
      slice_count <= c_slice;
      row_accum   <= a_row;
      slice_accum <= a_slice;
      if (!re) begin
        col_count <= c_col + dim_t'(1);
        col_accum <= a_col + steps.col;
      end else begin
        col_count <= '0;
        col_accum <= '0;
        if (!se) begin
          row_count <= c_row + dim_t'(1);
          row_accum <= a_row + steps.row;
        end else begin
          row_count <= '0;
          row_accum <= '0;
          if (!ve) begin
            slice_count <= c_slice + dim_t'(1);
            slice_accum <= a_slice + steps.slice;
          end else begin
            slice_count <= '0;
            slice_accum <= '0;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/nearest_neighbor_volume_resize.sv =====
// Top level of the nearest-neighbor 3D resize coordinate generator.
// Depends on nnvr_pkg, nnvr_div and nnvr_coord.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the six size
//    registers: source width/height/depth at 0..2, target width/height/depth at 3..5.
//    cfg_ready is always high; indexes past 5 are dropped.
//  - After a size write the per-axis steps (source/target in 13.16) are recomputed
//    by a shared restoring divider, one quotient bit per cycle: after a start step,
//    each axis is loaded and then produces its 29 quotient bits. in_ready stays low
//    until it finishes.
//  - Input channel: one beat per destination voxel in raster order, x fastest.
//    restart=1 returns counters to the origin before that voxel is served.
//  - Output channel: one beat per input beat, in the cycle after acceptance, from a
//    result register. With out_ready high and no step recompute under way, one voxel
//    per cycle is sustained; the rate is set by the counter/accumulator update loop.
//  - When the receiver stalls, the result holds and in_ready drops until it is taken.
//  - Reset (rst, synchronous) sets all sizes to 1, steps to 1.0 and counters to zero.
//  - After the beat carrying volume_end, the next volume starts at the origin.
module nearest_neighbor_volume_resize (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  nnvr_pkg::cfg_idx_t     cfg_index,
  input  nnvr_pkg::sz_t          cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   restart,
  output logic                   out_valid,
  input  logic                   out_ready,
  output nnvr_pkg::dim_t         src_col,
  output nnvr_pkg::dim_t         src_row,
  output nnvr_pkg::dim_t         src_plane,
  output nnvr_pkg::dim_t         dst_col,
  output nnvr_pkg::dim_t         dst_row,
  output nnvr_pkg::dim_t         dst_slice,
  output logic                   row_end,
  output logic                   slice_end,
  output logic                   volume_end
);
  import nnvr_pkg::*;

  sizes_t  src_size, dst_size;
  sizes_t  src_eff, dst_eff;
  tops_t   src_top, dst_top;
  steps_t  steps;
  logic    cfg_pend;
  logic    div_busy;
  logic    take;
  result_t gen_res;
  result_t res;

  assign cfg_ready = 1'b1;

  // Size registers; a write to a known index queues a step recompute
  always_ff @(posedge clk) begin
    if (rst) begin
      src_size <= '{col: MIN_SIZE, row: MIN_SIZE, slice: MIN_SIZE};
      dst_size <= '{col: MIN_SIZE, row: MIN_SIZE, slice: MIN_SIZE};
      cfg_pend <= 1'b0;
    end else begin
      cfg_pend <= cfg_valid && cfg_ready &&
                  (cfg_index inside {REG_SRC_W, REG_SRC_H, REG_SRC_D,
                                     REG_DST_W, REG_DST_H, REG_DST_D});
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SRC_W: src_size.col   <= cfg_data;
          REG_SRC_H: src_size.row   <= cfg_data;
          REG_SRC_D: src_size.slice <= cfg_data;
          REG_DST_W: dst_size.col   <= cfg_data;
          REG_DST_H: dst_size.row   <= cfg_data;
          REG_DST_D: dst_size.slice <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Effective sizes and top indexes
  always_comb begin
    src_eff.col   = eff_size(src_size.col);
    src_eff.row   = eff_size(src_size.row);
    src_eff.slice = eff_size(src_size.slice);
    dst_eff.col   = eff_size(dst_size.col);
    dst_eff.row   = eff_size(dst_size.row);
    dst_eff.slice = eff_size(dst_size.slice);
    src_top.col   = top_index(src_size.col);
    src_top.row   = top_index(src_size.row);
    src_top.slice = top_index(src_size.slice);
    dst_top.col   = top_index(dst_size.col);
    dst_top.row   = top_index(dst_size.row);
    dst_top.slice = top_index(dst_size.slice);
  end

  nnvr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_pend),
    .src   (src_eff),
    .dst   (dst_eff),
    .busy  (div_busy),
    .steps (steps)
  );

  // Accept while steps are settled and the result register is free or draining
  assign in_ready = !cfg_pend && !div_busy && (!out_valid || out_ready);
  assign take     = in_valid && in_ready;

  nnvr_coord u_coord (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .restart (restart),
    .steps   (steps),
    .src_top (src_top),
    .dst_top (dst_top),
    .res     (gen_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= gen_res;
    end
  end

  assign src_col    = res.src_col;
  assign src_row    = res.src_row;
  assign src_plane  = res.src_plane;
  assign dst_col    = res.dst_col;
  assign dst_row    = res.dst_row;
  assign dst_slice  = res.dst_slice;
  assign row_end    = res.row_end;
  assign slice_end  = res.slice_end;
  assign volume_end = res.volume_end;

  // No voxel is served while the steps are being recomputed
  a_no_take_while_div: assert property (@(posedge clk) disable iff (rst)
    take |-> (!div_busy && !cfg_pend))
    else $error("input beat accepted during step recompute");

  // A stalled result blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted over a stalled result");

  // Every accepted beat shows up on the output next cycle
  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("accepted beat produced no result");

  // End flags nest: volume end implies slice end implies row end
  a_end_nesting: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((!volume_end || slice_end) && (!slice_end || row_end)))
    else $error("end flags out of order");

endmodule
